/* rtl/core/quaternion_to_euler_angles_assert.svh */
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// condition implies consequence in the same cycle
`define Q2E_ASSERT_NOW(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("q2e assertion failed");

// condition implies consequence in the next cycle
`define Q2E_ASSERT_NEXT(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("q2e assertion failed");

`endif

/* rtl/core/q2e_pkg.sv */
package q2e_pkg;

   localparam int IN_W         = 16;
   localparam int PROD_W       = 2 * IN_W;
   localparam int OP_W         = PROD_W + 2;
   localparam int S_W          = 30;
   localparam int SQ_W         = 58;
   localparam int ROOT_W       = 29;
   localparam int SQRT_STEPS   = 29;
   localparam int CORDIC_STEPS = 18;
   localparam int LANE_W       = 37;
   localparam int Z_W          = 26;
   localparam int RND_W        = Z_W - 8;
   localparam int ANG_W        = 16;
   localparam int PITCH_W      = 15;
   localparam int LANE_LAT     = CORDIC_STEPS + 1;
   localparam int PITCH_DELAY  = 1 + SQRT_STEPS;
   localparam int VLD_N        = 4 + SQRT_STEPS + LANE_LAT;
   localparam int ANG_LIM      = 23040;
   localparam int PITCH_LIM    = 11520;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [OP_W-1:0]   op_type;
   typedef logic signed [S_W-1:0]    s_type;
   typedef logic        [SQ_W-1:0]   sq_type;
   typedef logic signed [LANE_W-1:0] lane_type;
   typedef logic signed [Z_W-1:0]    z_type;
   typedef logic signed [RND_W-1:0]  rnd_type;

   localparam op_type ONE_Q28   = op_type'(1) <<< 28;
   localparam sq_type ONE_Q56   = sq_type'(1) << 56;
   localparam z_type  DEG90_U16 = z_type'(90 * 65536);

   // atan(2^-i) in degrees times 2^16
   function automatic z_type atan_entry(input int step);
      z_type v;
      case (step)
         0:       v = z_type'(2949120);
         1:       v = z_type'(1740967);
         2:       v = z_type'(919879);
         3:       v = z_type'(466945);
         4:       v = z_type'(234379);
         5:       v = z_type'(117304);
         6:       v = z_type'(58666);
         7:       v = z_type'(29335);
         8:       v = z_type'(14668);
         9:       v = z_type'(7334);
         10:      v = z_type'(3667);
         11:      v = z_type'(1833);
         12:      v = z_type'(917);
         13:      v = z_type'(458);
         14:      v = z_type'(229);
         15:      v = z_type'(115);
         16:      v = z_type'(57);
         17:      v = z_type'(29);
         default: v = '0;
      endcase
      return v;
   endfunction

   // round to degrees*128, halves upward, then clamp
   function automatic rnd_type round_angle(input z_type z, input int lim);
      logic signed [Z_W:0] t;
      rnd_type r;
      rnd_type l;
      t = (Z_W+1)'(z) + (Z_W+1)'(256);
      r = RND_W'(t >>> 9);
      l = RND_W'(lim);
      if (r > l) begin
         r = l;
      end else if (r < -l) begin
         r = -l;
      end
      return r;
   endfunction

endpackage

/* rtl/core/q2e_sqrt_cell.sv */
module q2e_sqrt_cell
   import q2e_pkg::*;
#(
   parameter int BIT_POS = 0
) (
   input  logic   clock,
   input  logic   enable,
   input  sq_type rem_prev,
   input  sq_type root_prev,
   output sq_type rem_out,
   output sq_type root_out
);

   localparam sq_type BIT_VAL = sq_type'(1) << BIT_POS;

   sq_type rem_ff, rem_in;
   sq_type root_ff, root_in;
   sq_type trial;

   always_comb begin
      trial = root_prev + BIT_VAL;
      if (rem_prev >= trial) begin
         rem_in  = rem_prev - trial;
         root_in = (root_prev >> 1) + BIT_VAL;
      end else begin
         rem_in  = rem_prev;
         root_in = root_prev >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

/* rtl/core/q2e_cordic_cell.sv */
module q2e_cordic_cell
   import q2e_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     enable,
   input  lane_type x_prev,
   input  lane_type y_prev,
   input  z_type    z_prev,
   output lane_type x_out,
   output lane_type y_out,
   output z_type    z_out
);

   localparam z_type ANGLE = atan_entry(STEP);

   lane_type x_ff, x_in;
   lane_type y_ff, y_in;
   z_type    z_ff, z_in;
   lane_type xs, ys;

   always_comb begin
      xs = x_prev >>> STEP;
      ys = y_prev >>> STEP;
      x_in = x_prev;
      y_in = y_prev;
      z_in = z_prev;
      if (y_prev > lane_type'(0)) begin
         x_in = x_prev + ys;
         y_in = y_prev - xs;
         z_in = z_prev + ANGLE;
      end else if (y_prev < lane_type'(0)) begin
         x_in = x_prev - ys;
         y_in = y_prev + xs;
         z_in = z_prev - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

/* rtl/core/q2e_cordic_lane.sv */
module q2e_cordic_lane
   import q2e_pkg::*;
(
   input  logic     clock,
   input  logic     enable,
   input  lane_type num,
   input  lane_type den,
   output z_type    angle
);

   lane_type x_ff, x_in;
   lane_type y_ff, y_in;
   z_type    z_ff, z_in;

   lane_type xc [CORDIC_STEPS+1];
   lane_type yc [CORDIC_STEPS+1];
   z_type    zc [CORDIC_STEPS+1];

   // quadrant pre-rotation for a negative denominator
   always_comb begin
      x_in = den;
      y_in = num;
      z_in = '0;
      if (den < lane_type'(0)) begin
         if (num >= lane_type'(0)) begin
            x_in = num;
            y_in = -den;
            z_in = DEG90_U16;
         end else begin
            x_in = -num;
            y_in = den;
            z_in = -DEG90_U16;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign xc[0] = x_ff;
   assign yc[0] = y_ff;
   assign zc[0] = z_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      q2e_cordic_cell #(
         .STEP (i)
      ) u_cell (
         .clock  (clock),
         .enable (enable),
         .x_prev (xc[i]),
         .y_prev (yc[i]),
         .z_prev (zc[i]),
         .x_out  (xc[i+1]),
         .y_out  (yc[i+1]),
         .z_out  (zc[i+1])
      );
   end

   assign angle = zc[CORDIC_STEPS];

endmodule

/* rtl/core/quaternion_to_euler_angles.sv */
// Quaternion (w, x, y, z, signed Q2.14) to ZYX Euler angles: roll, pitch and yaw in degrees
// times 128. Fully pipelined: one quaternion is taken every cycle while req_stall is low.
// Its angles pass through the front end, the 29-step square-root chain that forms the
// pitch cosine, the 19-stage CORDIC lane (quadrant stage plus 18 micro-rotations) and the
// output register. Items flagged invalid are dropped at the input and give no result. The
// whole pipeline holds only while a result waits in the output register and the last stage
// carries a further result.
`include "quaternion_to_euler_angles_assert.svh"

module quaternion_to_euler_angles
   import q2e_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [IN_W-1:0]    req_quat_w,
   input  logic signed [IN_W-1:0]    req_quat_x,
   input  logic signed [IN_W-1:0]    req_quat_y,
   input  logic signed [IN_W-1:0]    req_quat_z,
   input  logic                      req_is_invalid,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ANG_W-1:0]   rsp_roll_deg,
   output logic signed [PITCH_W-1:0] rsp_pitch_deg,
   output logic signed [ANG_W-1:0]   rsp_yaw_deg
);

   logic adv;
   logic [VLD_N-1:0] vld_ff, vld_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [IN_W-1:0] w_ff, x_ff, y_ff, z_ff;
   prod_type wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, zx_ff;
   op_type   rn_ff, rd_ff, yn_ff, yd_ff;
   op_type   s_raw;
   s_type    s_ff, s_in;
   sq_type   ssq_ff;
   s_type    s_dly_ff [PITCH_DELAY];
   z_type    roll_dly_ff [PITCH_DELAY];
   z_type    yaw_dly_ff [PITCH_DELAY];

   sq_type   rem_c [SQRT_STEPS+1];
   sq_type   root_c [SQRT_STEPS+1];
   z_type    roll_z, pitch_z, yaw_z;

   logic signed [ANG_W-1:0]   roll_ff, yaw_ff;
   logic signed [PITCH_W-1:0] pitch_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall || !vld_ff[VLD_N-1];
   assign req_stall = !adv;

   assign vld_in = {vld_ff[VLD_N-2:0], req_valid && !req_is_invalid};

   always_comb begin
      s_raw = (op_type'(wy_ff) - op_type'(zx_ff)) <<< 1;
      if (s_raw > ONE_Q28) begin
         s_in = S_W'(ONE_Q28);
      end else if (s_raw < -ONE_Q28) begin
         s_in = S_W'(-ONE_Q28);
      end else begin
         s_in = S_W'(s_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // front end: input, products, sums, pitch radicand
   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff  <= req_quat_w;
         x_ff  <= req_quat_x;
         y_ff  <= req_quat_y;
         z_ff  <= req_quat_z;
         wx_ff <= w_ff * x_ff;
         yz_ff <= y_ff * z_ff;
         xx_ff <= x_ff * x_ff;
         yy_ff <= y_ff * y_ff;
         wz_ff <= w_ff * z_ff;
         xy_ff <= x_ff * y_ff;
         zz_ff <= z_ff * z_ff;
         wy_ff <= w_ff * y_ff;
         zx_ff <= z_ff * x_ff;
         rn_ff <= (op_type'(wx_ff) + op_type'(yz_ff)) <<< 1;
         rd_ff <= ONE_Q28 - ((op_type'(xx_ff) + op_type'(yy_ff)) <<< 1);
         yn_ff <= (op_type'(wz_ff) + op_type'(xy_ff)) <<< 1;
         yd_ff <= ONE_Q28 - ((op_type'(yy_ff) + op_type'(zz_ff)) <<< 1);
         s_ff  <= s_in;
         ssq_ff <= sq_type'(s_ff * s_ff);
      end
   end

   // alignment of roll, yaw and pitch sine with the root chain
   always_ff @(posedge clock) begin
      if (adv) begin
         s_dly_ff[0]    <= s_ff;
         roll_dly_ff[0] <= roll_z;
         yaw_dly_ff[0]  <= yaw_z;
         for (int i = 1; i < PITCH_DELAY; i++) begin
            s_dly_ff[i]    <= s_dly_ff[i-1];
            roll_dly_ff[i] <= roll_dly_ff[i-1];
            yaw_dly_ff[i]  <= yaw_dly_ff[i-1];
         end
      end
   end

   q2e_cordic_lane u_roll (
      .clock  (clock),
      .enable (adv),
      .num    (lane_type'(rn_ff)),
      .den    (lane_type'(rd_ff)),
      .angle  (roll_z)
   );

   q2e_cordic_lane u_yaw (
      .clock  (clock),
      .enable (adv),
      .num    (lane_type'(yn_ff)),
      .den    (lane_type'(yd_ff)),
      .angle  (yaw_z)
   );

   assign rem_c[0]  = ONE_Q56 - ssq_ff;
   assign root_c[0] = '0;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_root
      q2e_sqrt_cell #(
         .BIT_POS (2 * (SQRT_STEPS - 1 - i))
      ) u_cell (
         .clock     (clock),
         .enable    (adv),
         .rem_prev  (rem_c[i]),
         .root_prev (root_c[i]),
         .rem_out   (rem_c[i+1]),
         .root_out  (root_c[i+1])
      );
   end

   q2e_cordic_lane u_pitch (
      .clock  (clock),
      .enable (adv),
      .num    (lane_type'(s_dly_ff[PITCH_DELAY-1])),
      .den    (lane_type'({1'b0, root_c[SQRT_STEPS][ROOT_W-1:0]})),
      .angle  (pitch_z)
   );

   // output register
   assign rsp_valid_in = (adv && vld_ff[VLD_N-1]) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && vld_ff[VLD_N-1]) begin
         roll_ff  <= ANG_W'(round_angle(roll_dly_ff[PITCH_DELAY-1], ANG_LIM));
         pitch_ff <= PITCH_W'(round_angle(pitch_z, PITCH_LIM));
         yaw_ff   <= ANG_W'(round_angle(yaw_dly_ff[PITCH_DELAY-1], ANG_LIM));
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_roll_deg  = roll_ff;
   assign rsp_pitch_deg = pitch_ff;
   assign rsp_yaw_deg   = yaw_ff;

   `Q2E_ASSERT_NOW(a_stall_only_when_full, req_stall, rsp_valid_ff && rsp_stall && vld_ff[VLD_N-1])
   `Q2E_ASSERT_NEXT(a_invalid_dropped, req_valid && !req_stall && req_is_invalid, !vld_ff[0])
   `Q2E_ASSERT_NOW(a_pitch_range, rsp_valid_ff,
      rsp_pitch_deg <= PITCH_W'(PITCH_LIM) && rsp_pitch_deg >= -PITCH_W'(PITCH_LIM))
   `Q2E_ASSERT_NOW(a_roll_range, rsp_valid_ff,
      rsp_roll_deg <= ANG_W'(ANG_LIM) && rsp_roll_deg >= -ANG_W'(ANG_LIM))

endmodule

/* test/tb_top.sv */
module tb_top
   import q2e_pkg::*;
();

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [IN_W-1:0] req_quat_w = '0;
   logic signed [IN_W-1:0] req_quat_x = '0;
   logic signed [IN_W-1:0] req_quat_y = '0;
   logic signed [IN_W-1:0] req_quat_z = '0;
   logic req_is_invalid = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [ANG_W-1:0] rsp_roll_deg;
   logic signed [PITCH_W-1:0] rsp_pitch_deg;
   logic signed [ANG_W-1:0] rsp_yaw_deg;

   typedef struct packed {
      logic signed [ANG_W-1:0]   roll;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [ANG_W-1:0]   yaw;
   } angles_type;

   typedef struct {
      logic signed [IN_W-1:0] w, x, y, z;
      logic invalid;
      logic known;
      angles_type angles;
   } quat_row_type;

   angles_type pending_angles[$];
   int errors = 0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;
   bit long_hold = 1'b0;
   localparam int WATCHDOG = 20000;
   localparam int N_RANDOM = 850;

   quaternion_to_euler_angles dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint n);
      longint res, bit_v;
      res = 0;
      bit_v = longint'(1) << 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n = n - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, t, xs, ys;
      longint tab[CORDIC_STEPS] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
         58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 90 * 65536;
         end else begin
            x = -y; y = t; z = -90 * 65536;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = shift_floor(x, i);
         ys = shift_floor(y, i);
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + tab[i];
         end else if (y < 0) begin
            x = x - ys; y = y + xs; z = z - tab[i];
         end
      end
      return z;
   endfunction

   function automatic longint deg128(longint a, longint lim);
      longint r;
      r = shift_floor(a + 256, 9);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic angles_type euler_of(longint w, longint x, longint y, longint z);
      longint one, rn, rd, yn, yd, s, c;
      angles_type a;
      one = longint'(1) << 28;
      rn = 2 * (w * x + y * z);
      rd = one - 2 * (x * x + y * y);
      yn = 2 * (w * z + x * y);
      yd = one - 2 * (y * y + z * z);
      s = 2 * (w * y - z * x);
      if (s > one) s = one;
      if (s < -one) s = -one;
      c = int_sqrt(one * one - s * s);
      a.roll = ANG_W'(deg128(vector_angle(rn, rd), ANG_LIM));
      a.pitch = PITCH_W'(deg128(vector_angle(s, c), PITCH_LIM));
      a.yaw = ANG_W'(deg128(vector_angle(yn, yd), ANG_LIM));
      return a;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic send_quat(quat_row_type r);
      angles_type a;
      req_quat_w <= r.w;
      req_quat_x <= r.x;
      req_quat_y <= r.y;
      req_quat_z <= r.z;
      req_is_invalid <= r.invalid;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (!r.invalid) begin
         a = euler_of(r.w, r.x, r.y, r.z);
         if (r.known && a !== r.angles) begin
            report_mismatch("table row", a, r.angles);
         end
         pending_angles.push_back(r.known ? r.angles : a);
      end
      @(negedge clock);
   endtask

   function automatic logic signed [IN_W-1:0] rand_comp();
      case ($urandom_range(0, 4))
         0: return IN_W'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         2: return IN_W'(int'($urandom_range(0, 200)) - 100);
         default: return IN_W'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic quat_row_type unit_quat();
      quat_row_type r;
      real a, b, c, d, n;
      a = real'(int'($urandom_range(0, 2000)) - 1000);
      b = real'(int'($urandom_range(0, 2000)) - 1000);
      c = real'(int'($urandom_range(0, 2000)) - 1000);
      d = real'(int'($urandom_range(0, 2000)) - 1000);
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
      r.w = IN_W'($rtoi(a / n * 16384.0));
      r.x = IN_W'($rtoi(b / n * 16384.0));
      r.y = IN_W'($rtoi(c / n * 16384.0));
      r.z = IN_W'($rtoi(d / n * 16384.0));
      r.invalid = 1'b0;
      r.known = 1'b0;
      return r;
   endfunction

   // directed table: known rows carry the angles typed in
   quat_row_type directed[] = '{
      '{16384, 0, 0, 0, 1'b0, 1'b1, '{16'sd0, 15'sd0, 16'sd0}},
      '{0, 0, 0, 0, 1'b0, 1'b1, '{16'sd0, 15'sd0, 16'sd0}},
      '{0, 16384, 0, 0, 1'b0, 1'b1, '{16'sd23040, 15'sd0, 16'sd0}},
      '{0, 0, 0, 16384, 1'b0, 1'b1, '{16'sd0, 15'sd0, 16'sd23040}},
      '{11585, 0, 11585, 0, 1'b0, 1'b0, '{0, 0, 0}},
      '{11585, 0, -11585, 0, 1'b0, 1'b0, '{0, 0, 0}},
      '{16384, 0, 0, 0, 1'b1, 1'b0, '{0, 0, 0}},
      '{32767, 32767, 32767, 32767, 1'b0, 1'b0, '{0, 0, 0}},
      '{-32768, -32768, -32768, -32768, 1'b0, 1'b0, '{0, 0, 0}},
      '{32767, -32768, 32767, -32768, 1'b0, 1'b0, '{0, 0, 0}},
      '{-32768, 32767, 32767, -32768, 1'b0, 1'b0, '{0, 0, 0}},
      '{32767, 0, 32767, 0, 1'b0, 1'b0, '{0, 0, 0}},
      '{32767, 0, -32768, 0, 1'b0, 1'b0, '{0, 0, 0}},
      '{11585, 11585, 0, 0, 1'b0, 1'b0, '{0, 0, 0}},
      '{11585, 0, 0, 11585, 1'b0, 1'b0, '{0, 0, 0}},
      '{1, -1, 1, -1, 1'b0, 1'b0, '{0, 0, 0}},
      '{0, 0, 32767, 32767, 1'b0, 1'b0, '{0, 0, 0}},
      '{-32768, 32767, -32768, 32767, 1'b1, 1'b0, '{0, 0, 0}}
   };

   initial begin
      quat_row_type r;
      int burst;
      int gap;
      burst = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed[i]) send_quat(directed[i]);
      for (int n = 0; n < N_RANDOM; n++) begin
         if (burst == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst = $urandom_range(1, 40);
         end
         burst--;
         if ($urandom_range(0, 9) < 7) begin
            r = unit_quat();
         end else begin
            r.w = rand_comp();
            r.x = rand_comp();
            r.y = rand_comp();
            r.z = rand_comp();
            r.known = 1'b0;
         end
         r.invalid = ($urandom_range(0, 9) == 0);
         if (n == 300) long_hold = 1'b1;
         send_quat(r);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int mode;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (200) @(negedge clock);
            long_hold = 1'b0;
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(1, 30)) begin
            rsp_stall <= (mode == 0) ? 1'b0 : (mode == 1) ? 1'b1 : ($urandom_range(0, 2) == 0);
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      angles_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_angles.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = pending_angles.pop_front();
            if (rsp_roll_deg !== want.roll) report_mismatch("roll", rsp_roll_deg, want.roll);
            if (rsp_pitch_deg !== want.pitch)
               report_mismatch("pitch", rsp_pitch_deg, want.pitch);
            if (rsp_yaw_deg !== want.yaw) report_mismatch("yaw", rsp_yaw_deg, want.yaw);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (VLD_N + 20) @(posedge clock);
      if (errors == 0 && pending_angles.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
